### hdl/skp_pkg.sv
package skp_pkg;

   localparam int MAX_SPANS = 256;
   localparam int MAX_DIM   = 4096;
   localparam int IDX_W     = $clog2(MAX_SPANS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int DIM_W     = 13;
   localparam int POS_W     = 12;
   localparam int WASTE_W   = 2 * DIM_W;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_SIZE = 2'd1;
   localparam logic [1:0] ST_NO_FIT   = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic CSR_AREA_WIDTH  = 1'b0;
   localparam logic CSR_AREA_HEIGHT = 1'b1;

   typedef struct packed {
      logic [POS_W-1:0] start;
      logic [DIM_W-1:0] top;
      logic [DIM_W-1:0] len;
   } span_type;

   typedef struct packed {
      logic             kind;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } cmd_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
   } res_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

endpackage

### hdl/skp_req_if.sv
interface skp_req_if;
   import skp_pkg::*;
   logic             valid;
   logic             ready;
   logic             kind;
   logic [DIM_W-1:0] req_width;
   logic [DIM_W-1:0] req_height;
   modport source (output valid, kind, req_width, req_height, input ready);
   modport sink (input valid, kind, req_width, req_height, output ready);
endinterface

### hdl/skp_rsp_if.sv
interface skp_rsp_if;
   import skp_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   modport source (output valid, status, pos_x, pos_y, input ready);
   modport sink (input valid, status, pos_x, pos_y, output ready);
endinterface

### hdl/skp_engine.sv
module skp_engine
   import skp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cmd_type          cmd,
   input  logic [DIM_W-1:0] area_width,
   input  logic [DIM_W-1:0] area_height,
   input  logic             out_free,
   output logic             idle,
   output logic             done,
   output res_type          res
);

   localparam logic [3:0] S_FLAT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RI    = 4'd2;
   localparam logic [3:0] S_GI    = 4'd3;
   localparam logic [3:0] S_RK    = 4'd4;
   localparam logic [3:0] S_GK    = 4'd5;
   localparam logic [3:0] S_ACC   = 4'd6;
   localparam logic [3:0] S_EVAL  = 4'd7;
   localparam logic [3:0] S_CHK   = 4'd8;
   localparam logic [3:0] S_BR    = 4'd9;
   localparam logic [3:0] S_BG    = 4'd10;
   localparam logic [3:0] S_RECT  = 4'd11;
   localparam logic [3:0] S_FLUSH = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   span_type mem [0:2*MAX_SPANS-1];
   span_type rd_data_ff;
   logic [IDX_W:0] rd_addr;
   logic           wr_en;
   logic [IDX_W:0] wr_addr;
   span_type       wr_data;

   logic [3:0]         state_ff, state_in;
   logic               bank_ff, bank_in;
   logic               clr_ff, clr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DIM_W-1:0]   aw_ff, aw_in, ah_ff, ah_in;
   logic [DIM_W-1:0]   w_ff, w_in, h_ff, h_in;
   logic [CNT_W-1:0]   i_ff, i_in, k_ff, k_in;
   logic [POS_W-1:0]   x_ff, x_in;
   logic [DIM_W:0]     xe_ff, xe_in;
   logic [DIM_W-1:0]   topi_ff, topi_in, y_ff, y_in;
   logic [WASTE_W-1:0] waste_ff, waste_in, prod_ff, prod_in;
   logic               found_ff, found_in;
   logic [POS_W-1:0]   bx_ff, bx_in;
   logic [DIM_W-1:0]   by_ff, by_in;
   logic [WASTE_W-1:0] bw_ff, bw_in;
   logic               phase_ff, phase_in;
   logic [CNT_W-1:0]   ncnt_ff, ncnt_in;
   logic               ovf_ff, ovf_in;
   span_type           pend_ff, pend_in;
   logic               pend_v_ff, pend_v_in;
   res_type            res_ff, res_in;

   logic             em_v;
   span_type         em;
   logic [DIM_W:0]   d_end, xe_full, yh;
   logic [DIM_W-1:0] hi, lo, bx_ext;
   logic [CNT_W-1:0] i_next;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign idle = (state_ff == S_IDLE);
   assign res  = res_ff;
   assign i_next = i_ff + CNT_W'(1);
   assign d_end = {1'b0, DIM_W'(rd_data_ff.start)} + {1'b0, rd_data_ff.len};
   assign bx_ext = DIM_W'(bx_ff);
   assign xe_full = {1'b0, bx_ext} + {1'b0, w_ff};
   assign yh = {1'b0, y_ff} + {1'b0, h_ff};

   always_comb begin
      state_in = state_ff;  bank_in = bank_ff;  clr_in = clr_ff;
      count_in = count_ff;  aw_in = aw_ff;      ah_in = ah_ff;
      w_in = w_ff;          h_in = h_ff;        i_in = i_ff;
      k_in = k_ff;          x_in = x_ff;        xe_in = xe_ff;
      topi_in = topi_ff;    y_in = y_ff;        waste_in = waste_ff;
      prod_in = prod_ff;    found_in = found_ff;
      bx_in = bx_ff;        by_in = by_ff;      bw_in = bw_ff;
      phase_in = phase_ff;  ncnt_in = ncnt_ff;  ovf_in = ovf_ff;
      pend_in = pend_ff;    pend_v_in = pend_v_ff;
      res_in = res_ff;
      rd_addr = {bank_ff, i_ff[IDX_W-1:0]};
      wr_en = 1'b0;
      wr_addr = {bank_ff, {IDX_W{1'b0}}};
      wr_data = pend_ff;
      em_v = 1'b0;
      em = rd_data_ff;
      hi = '0;
      lo = '0;
      done = 1'b0;

      unique case (state_ff)
         S_FLAT: begin
            wr_en = 1'b1;
            wr_data = '{start: '0, top: '0, len: aw_ff};
            count_in = CNT_W'(1);
            state_in = clr_ff ? S_DONE : S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               res_in = '{status: ST_OK, pos_x: '0, pos_y: '0};
               w_in = cmd.width;
               h_in = cmd.height;
               if (cmd.kind) begin
                  aw_in = clamp_dim(area_width);
                  ah_in = clamp_dim(area_height);
                  clr_in = 1'b1;
                  state_in = S_FLAT;
               end else if (cmd.width == '0 || cmd.height == '0 ||
                            cmd.width > aw_ff || cmd.height > ah_ff) begin
                  res_in.status = ST_BAD_SIZE;
                  state_in = S_DONE;
               end else begin
                  i_in = '0;
                  found_in = 1'b0;
                  state_in = S_RI;
               end
            end
         end
         S_RI: begin
            state_in = S_GI;
         end
         S_GI: begin
            x_in = rd_data_ff.start;
            xe_in = {1'b0, DIM_W'(rd_data_ff.start)} + {1'b0, w_ff};
            topi_in = rd_data_ff.top;
            y_in = rd_data_ff.top;
            waste_in = '0;
            k_in = i_ff;
            if (({1'b0, DIM_W'(rd_data_ff.start)} + {1'b0, w_ff}) > {1'b0, aw_ff}) begin
               i_in = i_next;
               state_in = (i_next < count_ff) ? S_RI : S_CHK;
            end else begin
               state_in = S_RK;
            end
         end
         S_RK: begin
            rd_addr = {bank_ff, k_ff[IDX_W-1:0]};
            state_in = S_GK;
         end
         S_GK: begin
            if (k_ff < count_ff && {1'b0, DIM_W'(rd_data_ff.start)} < xe_ff) begin
               if (rd_data_ff.top > y_ff) begin
                  y_in = rd_data_ff.top;
               end
               hi = (d_end < xe_ff) ? d_end[DIM_W-1:0] : xe_ff[DIM_W-1:0];
               if (rd_data_ff.top > topi_ff) begin
                  prod_in = (hi - DIM_W'(rd_data_ff.start)) * (rd_data_ff.top - topi_ff);
               end else begin
                  prod_in = '0;
               end
               state_in = S_ACC;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_ACC: begin
            waste_in = waste_ff + prod_ff;
            k_in = k_ff + CNT_W'(1);
            state_in = S_RK;
         end
         S_EVAL: begin
            if (yh <= {1'b0, ah_ff} &&
                (!found_ff || y_ff < by_ff || (y_ff == by_ff && waste_ff < bw_ff))) begin
               found_in = 1'b1;
               bx_in = x_ff;
               by_in = y_ff;
               bw_in = waste_ff;
            end
            i_in = i_next;
            state_in = (i_next < count_ff) ? S_RI : S_CHK;
         end
         S_CHK: begin
            if (!found_ff) begin
               res_in.status = ST_NO_FIT;
               state_in = S_DONE;
            end else begin
               phase_in = 1'b0;
               i_in = '0;
               ncnt_in = '0;
               ovf_in = 1'b0;
               pend_v_in = 1'b0;
               state_in = S_BR;
            end
         end
         S_BR: begin
            state_in = S_BG;
         end
         S_BG: begin
            if (!phase_ff) begin
               hi = (d_end < {1'b0, bx_ext}) ? d_end[DIM_W-1:0] : bx_ext;
               em_v = rd_data_ff.start < bx_ff;
               em.len = hi - DIM_W'(rd_data_ff.start);
            end else begin
               lo = ({1'b0, DIM_W'(rd_data_ff.start)} > xe_full) ?
                    DIM_W'(rd_data_ff.start) : xe_full[DIM_W-1:0];
               em_v = d_end > xe_full;
               em.start = lo[POS_W-1:0];
               em.len = d_end[DIM_W-1:0] - lo;
            end
            i_in = i_next;
            if (i_next >= count_ff) begin
               state_in = phase_ff ? S_FLUSH : S_RECT;
            end else begin
               state_in = S_BR;
            end
         end
         S_RECT: begin
            em_v = 1'b1;
            em = '{start: bx_ff, top: by_ff + h_ff, len: w_ff};
            phase_in = 1'b1;
            i_in = '0;
            state_in = S_BR;
         end
         S_FLUSH: begin
            if (ovf_ff) begin
               res_in.status = ST_FULL;
            end else begin
               wr_en = 1'b1;
               wr_addr = {!bank_ff, IDX_W'(ncnt_ff - CNT_W'(1))};
               wr_data = pend_ff;
               count_in = ncnt_ff;
               bank_in = !bank_ff;
               res_in.pos_x = bx_ff;
               res_in.pos_y = by_ff[POS_W-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               done = 1'b1;
               clr_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (em_v && em.len != '0) begin
         if (pend_v_ff && pend_ff.top == em.top) begin
            pend_in.len = pend_ff.len + em.len;
         end else if (ncnt_ff >= CNT_W'(MAX_SPANS)) begin
            ovf_in = 1'b1;
         end else begin
            if (pend_v_ff) begin
               wr_en = 1'b1;
               wr_addr = {!bank_ff, IDX_W'(ncnt_ff - CNT_W'(1))};
               wr_data = pend_ff;
            end
            pend_in = em;
            pend_v_in = 1'b1;
            ncnt_in = ncnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FLAT;
         bank_ff <= 1'b0;
         clr_ff <= 1'b0;
         count_ff <= CNT_W'(1);
         aw_ff <= DIM_W'(1024);
         ah_ff <= DIM_W'(1024);
         found_ff <= 1'b0;
         phase_ff <= 1'b0;
         ovf_ff <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bank_ff <= bank_in;
         clr_ff <= clr_in;
         count_ff <= count_in;
         aw_ff <= aw_in;
         ah_ff <= ah_in;
         found_ff <= found_in;
         phase_ff <= phase_in;
         ovf_ff <= ovf_in;
         pend_v_ff <= pend_v_in;
      end
      w_ff <= w_in;        h_ff <= h_in;
      i_ff <= i_in;        k_ff <= k_in;
      x_ff <= x_in;        xe_ff <= xe_in;
      topi_ff <= topi_in;  y_ff <= y_in;
      waste_ff <= waste_in;
      prod_ff <= prod_in;
      bx_ff <= bx_in;      by_ff <= by_in;     bw_ff <= bw_in;
      ncnt_ff <= ncnt_in;  pend_ff <= pend_in;
      res_ff <= res_in;
   end

endmodule

### hdl/skyline_rect_packer.sv
// skyline rectangle packer
// req channel: one transfer per request, kind 0 places a req_width by
//   req_height rectangle, kind 1 resets the skyline to one flat span
// rsp channel: one transfer per request, in request order, with status and
//   the bottom-left position of a placed rectangle
// csr port: write the area width (index 0) or height (index 1); the values
//   take effect at the next clear; reset sets both back to 1024
// a clear rewrites the flat span; a bad size goes straight to the result;
//   an allocate scans every span start, reading the spans under the
//   footprint of each start that fits the width, then rebuilds the table
//   in two passes around the placed rectangle (not on no fit), and the
//   engine then waits in its done state to hand over the result
// every step makes at most one read and one write of the span memory (one
//   read port, one write port, two banks swapped on commit)
// one request is worked on at a time; req.ready is high while the engine
//   is idle, also while a finished result waits in the rsp register
// reset: the skyline is set flat in the first cycle after reset, req.ready
//   rises in the cycle after that
// a stalled rsp holds its result and the engine waits before finishing
module skyline_rect_packer
   import skp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   skp_req_if.sink          req,
   skp_rsp_if.source        rsp,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [DIM_W-1:0] csr_data
);

   logic [DIM_W-1:0] pw_ff, pw_in, ph_ff, ph_in;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_ff, rsp_in;
   logic             eng_idle, eng_done, out_free;
   res_type          eng_res;
   cmd_type          cmd;

   assign cmd = '{kind: req.kind, width: req.req_width, height: req.req_height};
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = eng_idle;

   skp_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (req.valid && eng_idle),
      .cmd         (cmd),
      .area_width  (pw_ff),
      .area_height (ph_ff),
      .out_free    (out_free),
      .idle        (eng_idle),
      .done        (eng_done),
      .res         (eng_res)
   );

   always_comb begin
      pw_in = pw_ff;
      ph_in = ph_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_AREA_WIDTH:  pw_in = csr_data;
            CSR_AREA_HEIGHT: ph_in = csr_data;
            default: begin
            end
         endcase
      end
      rsp_in = eng_done ? eng_res : rsp_ff;
      rsp_valid_in = eng_done ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff <= DIM_W'(1024);
         ph_ff <= DIM_W'(1024);
         rsp_valid_ff <= 1'b0;
      end else begin
         pw_ff <= pw_in;
         ph_ff <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.status = rsp_ff.status;
   assign rsp.pos_x  = rsp_ff.pos_x;
   assign rsp.pos_y  = rsp_ff.pos_y;

endmodule

### bench/skyline_rect_packer_tb.sv
`timescale 1ns / 1ps

module skyline_rect_packer_tb;
   import skp_pkg::*;

   class packer_scoreboard;
      int unsigned page_w = 1024, page_h = 1024, act_w, act_h;
      int unsigned sp_start[$], sp_top[$], sp_len[$];
      int unsigned nx_start[$], nx_top[$], nx_len[$];
      bit nx_ovf;
      res_type expected_q[$];
      int errors = 0;

      function new();
         flatten();
      endfunction

      function int unsigned clampd(int unsigned v);
         if (v == 0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      function void flatten();
         act_w = clampd(page_w);
         act_h = clampd(page_h);
         sp_start = {0};
         sp_top = {0};
         sp_len = {act_w};
      endfunction

      function void add_piece(int unsigned s, int unsigned t, int unsigned l);
         if (l == 0) return;
         if (nx_top.size() > 0 && nx_top[$] == t) begin
            nx_len[nx_len.size()-1] += l;
            return;
         end
         if (nx_top.size() >= MAX_SPANS) begin
            nx_ovf = 1;
            return;
         end
         nx_start = {nx_start, s};
         nx_top = {nx_top, t};
         nx_len = {nx_len, l};
      endfunction

      function void note_request(bit kind, int unsigned w, int unsigned h);
         res_type r;
         int unsigned n, x, xe, y, s, e, lo, hi, bx, by;
         longint unsigned waste, bw;
         bit found;
         int j;
         r = '0;
         found = 0;
         bx = 0;
         by = 0;
         bw = 0;
         n = sp_start.size();
         if (kind) begin
            flatten();
         end else if (w == 0 || h == 0 || w > act_w || h > act_h) begin
            r.status = ST_BAD_SIZE;
         end else begin
            for (int i = 0; i < n; i++) begin
               x = sp_start[i];
               xe = x + w;
               y = sp_top[i];
               waste = 0;
               if (xe > act_w) continue;
               for (j = i; j < n && sp_start[j] < xe; j++)
                  if (sp_top[j] > y) y = sp_top[j];
               if (y + h > act_h) continue;
               for (int k = i; k < j; k++) begin
                  s = sp_start[k];
                  e = s + sp_len[k];
                  lo = s > x ? s : x;
                  hi = e < xe ? e : xe;
                  if (hi > lo && sp_top[k] > sp_top[i])
                     waste += longint'(hi - lo) * longint'(sp_top[k] - sp_top[i]);
               end
               if (!found || y < by || (y == by && waste < bw)) begin
                  found = 1;
                  bx = x;
                  by = y;
                  bw = waste;
               end
            end
            if (!found) begin
               r.status = ST_NO_FIT;
            end else begin
               xe = bx + w;
               nx_start.delete();
               nx_top.delete();
               nx_len.delete();
               nx_ovf = 0;
               for (int i = 0; i < n; i++) begin
                  s = sp_start[i];
                  e = s + sp_len[i];
                  if (s < bx) add_piece(s, sp_top[i], (e < bx ? e : bx) - s);
               end
               add_piece(bx, by + h, w);
               for (int i = 0; i < n; i++) begin
                  s = sp_start[i];
                  e = s + sp_len[i];
                  if (e > xe) begin
                     lo = s > xe ? s : xe;
                     add_piece(lo, sp_top[i], e - lo);
                  end
               end
               if (nx_ovf) begin
                  r.status = ST_FULL;
               end else begin
                  sp_start = nx_start;
                  sp_top = nx_top;
                  sp_len = nx_len;
                  r.pos_x = POS_W'(bx);
                  r.pos_y = POS_W'(by);
               end
            end
         end
         expected_q = {expected_q, r};
      endfunction

      function void check_result(res_type got);
         res_type want;
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
         end
         if (got.pos_x !== want.pos_x) begin
            $error("pos_x expected %0d actual %0d", want.pos_x, got.pos_x);
            errors++;
         end
         if (got.pos_y !== want.pos_y) begin
            $error("pos_y expected %0d actual %0d", want.pos_y, got.pos_y);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 600000;

   logic clock = 0;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [DIM_W-1:0] csr_data;

   skp_req_if req ();
   skp_rsp_if rsp ();

   skyline_rect_packer dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   packer_scoreboard placements = new();
   bit send_idle = 1, recv_idle = 1, hold_off = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side
   initial begin
      int gap;
      res_type got;
      forever begin
         if (hold_off) begin
            rsp.ready <= 0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         gap = recv_idle ? $urandom_range(0, 14) : 0;
         if (gap > 0) begin
            rsp.ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1;
         do @(posedge clock); while (!rsp.valid);
         got.status = rsp.status;
         got.pos_x = rsp.pos_x;
         got.pos_y = rsp.pos_y;
         placements.check_result(got);
      end
   end

   task automatic send(bit kind, int unsigned w, int unsigned h);
      int gap;
      gap = send_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.kind <= kind;
      req.req_width <= DIM_W'(w);
      req.req_height <= DIM_W'(h);
      do @(posedge clock); while (!req.ready);
      placements.note_request(kind, w, h);
   endtask

   task automatic drain();
      req.valid <= 0;
      while (placements.expected_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic index, int unsigned value);
      csr_we <= 1;
      csr_index <= index;
      csr_data <= DIM_W'(value);
      @(posedge clock);
      csr_we <= 0;
      if (index == CSR_AREA_WIDTH) placements.page_w = value;
      else placements.page_h = value;
      @(posedge clock);
   endtask

   task automatic set_page(int unsigned w, int unsigned h);
      write_reg(CSR_AREA_WIDTH, w);
      write_reg(CSR_AREA_HEIGHT, h);
      send(1, 0, 0);
   endtask

   function automatic int unsigned pick_dim();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 4096;
         2: return 8191;
         3: return $urandom_range(1, 64);
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   initial begin
      int unsigned aw, ah;
      reset <= 1;
      csr_we <= 0;
      csr_index <= CSR_AREA_WIDTH;
      csr_data <= '0;
      req.valid <= 0;
      req.kind <= 0;
      req.req_width <= '0;
      req.req_height <= '0;
      repeat (8) @(posedge clock);
      reset <= 0;

      // default page, extremes and error cases
      send(0, 1024, 1024);
      send(0, 1, 1);
      send(0, 0, 5);
      send(0, 5, 0);
      send(0, 1025, 1);
      send(1, 0, 0);
      send(0, 300, 200);
      send(0, 300, 500);
      send(0, 500, 100);
      send(0, 1024, 1000);
      send(0, 8191, 8191);
      drain();
      set_page(4096, 4096);
      send(0, 4096, 1);
      send(0, 2100, 2100);
      send(0, 2000, 4095);
      send(0, 4097, 1);
      drain();
      set_page(0, 8191);
      send(0, 1, 4096);
      send(0, 2, 1);
      send(0, 1, 1);
      drain();
      set_page(3, 0);
      send(0, 1, 1);
      send(0, 3, 1);
      drain();

      // fill the span table with alternating thin columns
      send_idle = 0;
      recv_idle = 0;
      set_page(300, 8);
      for (int i = 0; i < 258; i++) send(0, 1, 1 + (i % 2));
      drain();
      send_idle = 1;
      recv_idle = 1;

      for (int phase = 0; phase < 12; phase++) begin
         if ($urandom_range(0, 1)) write_reg(CSR_AREA_WIDTH, pick_dim());
         write_reg(CSR_AREA_HEIGHT, pick_dim());
         if ($urandom_range(0, 1)) send(0, $urandom_range(1, 300), $urandom_range(1, 300));
         send(1, 0, 0);
         send_idle = (phase % 4) != 1;
         recv_idle = (phase % 4) != 2;
         if (phase == 5) hold_off = 1;
         aw = placements.act_w;
         ah = placements.act_h;
         for (int i = 0; i < 26; i++) begin
            case ($urandom_range(0, 19))
               0: send(0, $urandom_range(0, 8191), $urandom_range(0, 8191));
               1: send(0, 0, $urandom_range(0, 8191));
               2: send(1, $urandom_range(0, 8191), $urandom_range(0, 8191));
               3: send(0, aw, $urandom_range(1, ah));
               default: send(0, $urandom_range(1, aw > 3 ? aw / 3 : 1),
                              $urandom_range(1, ah > 4 ? ah / 4 : 1));
            endcase
         end
         drain();
      end

      if (placements.errors == 0 && placements.expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (placements.expected_q.size() > 0)
            $error("%0d results never arrived", placements.expected_q.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule
